// ===== rtl/core/tspnp_pkg.sv =====
// Shared types, constants and helpers for the TS PID null patcher.
package tspnp_pkg;

  localparam int unsigned PacketBytes = 188;
  localparam int unsigned MaxPids     = 16;
  localparam int unsigned PidW        = 13;
  localparam int unsigned WordW       = 52;
  localparam int unsigned PidsPerWord = WordW / PidW;
  localparam int unsigned NumWords    = MaxPids / PidsPerWord;
  localparam int unsigned CntW        = 5;
  localparam int unsigned IdxW        = 3;
  localparam int unsigned LenW        = 11;
  localparam int unsigned PosW        = 8;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned PtrW        = 2;
  localparam int unsigned FillW       = 3;

  localparam logic [7:0]        SyncByte  = 8'h47;
  localparam logic [7:0]        NullLow   = 8'hFF;
  localparam logic [4:0]        PidHiMask = 5'h1F;
  localparam logic [PosW-1:0]   LastPos   = PosW'(PacketBytes - 1);
  // ceil(2^19 / 188): exact quotient for every 11-bit length
  localparam logic [11:0]       LenRecip  = 12'd2789;
  localparam int unsigned       RecipSh   = 19;

  typedef enum logic [IdxW-1:0] {
    CfgPidCount = 3'd0,
    CfgPidWordA = 3'd1,
    CfgPidWordB = 3'd2,
    CfgPidWordC = 3'd3,
    CfgPidWordD = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic       last_of_step;
    logic       sync_error;
    logic       pid_replaced;
    logic       end_of_datagram;
    logic [7:0] out_byte;
  } res_t;

  // length mod 188 through a reciprocal multiply and a table of multiples
  function automatic logic [PosW-1:0] len_mod_packet(input logic [LenW-1:0] len);
    logic [22:0]     prod;
    logic [3:0]      quo;
    logic [LenW-1:0] mult;
    logic [LenW-1:0] rem;
    prod = 23'(len) * 23'(LenRecip);
    quo  = prod[RecipSh +: 4];
    case (quo)
      4'd0:    mult = 11'd0;
      4'd1:    mult = 11'd188;
      4'd2:    mult = 11'd376;
      4'd3:    mult = 11'd564;
      4'd4:    mult = 11'd752;
      4'd5:    mult = 11'd940;
      4'd6:    mult = 11'd1128;
      4'd7:    mult = 11'd1316;
      4'd8:    mult = 11'd1504;
      4'd9:    mult = 11'd1692;
      4'd10:   mult = 11'd1880;
      default: mult = 11'd0;
    endcase
    rem = len - mult;
    return rem[PosW-1:0];
  endfunction

endpackage

// ===== rtl/core/ts_pid_null_patcher_core.sv =====
// Top level: TS PID null patcher, one byte word in per ready cycle, up to two results out.
// Result words enter the registered result queue when their input word is accepted.
// Throughput: one input word per cycle while the sink keeps up; byte1 of a synced packet
// emits nothing and byte2 two words, so a 4-entry result queue keeps the rate at one per cycle.
// Input ready drops only while the result queue holds three or more words.
// Reset (async, active low) clears packet state, PID table, count and the queue.
module ts_pid_null_patcher_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [23:0]                         s_axis_tdata_i,  // in_byte, datagram_length, pad
  input  logic                                s_axis_tlast_i,  // last_of_datagram
  input  logic [0:0]                          s_axis_tuser_i,  // first_of_datagram
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [7:0]                          m_axis_tdata_o,  // out_byte
  output logic                                m_axis_tlast_o,  // end_of_datagram
  output logic [2:0]                          m_axis_tuser_o,  // pid_replaced, sync_error,
                                                               // last_of_step
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tspnp_pkg::IdxW-1:0]          cfg_index_i,
  input  logic [tspnp_pkg::WordW-1:0]         cfg_data_i
);
  import tspnp_pkg::*;

  logic [CntW-1:0]  pid_count_q;
  logic [WordW-1:0] pid_words_q [NumWords];

  logic [PosW-1:0]  hdr_left_q, hdr_left_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [7:0]       held_q, held_d;
  logic             sync_ok_q, sync_ok_d;
  logic             in_hdr_q, in_hdr_d;

  res_t             fifo_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;

  logic             in_fire, out_fire, cfg_fire;
  logic [7:0]       in_byte;
  logic [LenW-1:0]  in_len;
  logic             in_first, in_last;
  res_t             res0, res1;
  logic [1:0]       n_res;
  logic             pid_hit;

  assign in_byte  = s_axis_tdata_i[7:0];
  assign in_len   = s_axis_tdata_i[8 +: LenW];
  assign in_first = s_axis_tuser_i[0];
  assign in_last  = s_axis_tlast_i;

  assign s_axis_tready_o = (fill_q < FillW'(FifoDepth - 1));
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = (fill_q != '0);
  assign out_fire        = m_axis_tvalid_o & m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;
  assign cfg_fire        = cfg_valid_i & cfg_ready_o;

  assign m_axis_tdata_o = fifo_q[rd_ptr_q].out_byte;
  assign m_axis_tlast_o = fifo_q[rd_ptr_q].end_of_datagram;
  assign m_axis_tuser_o = {fifo_q[rd_ptr_q].last_of_step, fifo_q[rd_ptr_q].sync_error,
                           fifo_q[rd_ptr_q].pid_replaced};

  // PID table compare, entries at or beyond the count are ignored
  always_comb begin
    logic [PidW-1:0] pid;
    logic [CntW-1:0] n_cmp;
    logic [PidW-1:0] entry;
    pid     = {held_q[4:0], in_byte};
    n_cmp   = (pid_count_q > CntW'(MaxPids)) ? CntW'(MaxPids) : pid_count_q;
    pid_hit = 1'b0;
    for (int i = 0; i < MaxPids; i++) begin
      entry = pid_words_q[i / PidsPerWord][(i % PidsPerWord) * PidW +: PidW];
      if ((CntW'(i) < n_cmp) && (entry == pid)) begin
        pid_hit = 1'b1;
      end
    end
  end

  // per-word packet state update and result generation
  always_comb begin
    logic pending;
    logic pre;
    res_t m0, m1;
    logic [1:0] n_main;
    logic adv;

    hdr_left_d = hdr_left_q;
    pos_d      = pos_q;
    held_d     = held_q;
    sync_ok_d  = sync_ok_q;
    in_hdr_d   = in_hdr_q;
    m0         = '0;
    m1         = '0;
    n_main     = 2'd0;
    adv        = 1'b0;
    pre        = 1'b0;
    pending    = (pos_q == PosW'(2)) && sync_ok_q && !in_hdr_q;

    if (in_first) begin
      if (pending) begin
        pre       = 1'b1;
        sync_ok_d = 1'b0;
      end
      hdr_left_d = len_mod_packet(in_len);
      pos_d      = '0;
      in_hdr_d   = (hdr_left_d != '0);
      pending    = 1'b0;
    end

    m0.out_byte        = in_byte;
    m0.end_of_datagram = in_last;

    if (in_hdr_d) begin
      n_main = 2'd1;
      if (hdr_left_d != '0) begin
        hdr_left_d = hdr_left_d - PosW'(1);
      end
      if (hdr_left_d == '0) begin
        in_hdr_d = 1'b0;
      end
    end else if (pos_d == '0) begin
      sync_ok_d     = (in_byte == SyncByte);
      m0.sync_error = !sync_ok_d;
      n_main        = 2'd1;
      adv           = 1'b1;
    end else if (pos_d == PosW'(1)) begin
      if (sync_ok_d && !in_last) begin
        held_d = in_byte;
      end else begin
        sync_ok_d = 1'b0;
        n_main    = 2'd1;
      end
      adv = 1'b1;
    end else if (pending) begin
      n_main             = 2'd2;
      m0.end_of_datagram = 1'b0;
      m1.end_of_datagram = in_last;
      if (pid_hit) begin
        m0.out_byte     = held_q | {3'b000, PidHiMask};
        m0.pid_replaced = 1'b1;
        m1.out_byte     = NullLow;
        m1.pid_replaced = 1'b1;
      end else begin
        m0.out_byte = held_q;
        m1.out_byte = in_byte;
      end
      adv = 1'b1;
    end else begin
      n_main = 2'd1;
      adv    = 1'b1;
    end

    if (adv) begin
      pos_d = (pos_d == LastPos) ? '0 : pos_d + PosW'(1);
    end

    if (pre) begin
      res0          = '0;
      res0.out_byte = held_q;
      res1          = m0;
    end else begin
      res0 = m0;
      res1 = m1;
    end
    n_res = n_main + {1'b0, pre};
    if (n_res == 2'd1) begin
      res0.last_of_step = 1'b1;
    end
    if (n_res == 2'd2) begin
      res1.last_of_step = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_left_q <= '0;
      pos_q      <= '0;
      held_q     <= '0;
      sync_ok_q  <= 1'b0;
      in_hdr_q   <= 1'b0;
    end else if (in_fire) begin
      hdr_left_q <= hdr_left_d;
      pos_q      <= pos_d;
      held_q     <= held_d;
      sync_ok_q  <= sync_ok_d;
      in_hdr_q   <= in_hdr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_count_q <= '0;
      for (int i = 0; i < NumWords; i++) begin
        pid_words_q[i] <= '0;
      end
    end else if (cfg_fire) begin
      case (cfg_index_i)
        CfgPidCount: pid_count_q    <= cfg_data_i[CntW-1:0];
        CfgPidWordA: pid_words_q[0] <= cfg_data_i;
        CfgPidWordB: pid_words_q[1] <= cfg_data_i;
        CfgPidWordC: pid_words_q[2] <= cfg_data_i;
        CfgPidWordD: pid_words_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (in_fire && (n_res != 2'd0)) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (in_fire && (n_res == 2'd2)) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      fill_q <= fill_q + (in_fire ? FillW'(n_res) : '0) - FillW'(out_fire);
    end
  end

endmodule

// ===== rtl/core/tspnp_checker.sv =====
// Port-level checker for the TS PID null patcher, bound to the top level.
module tspnp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic [2:0]  m_axis_tuser_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
       && $stable(m_axis_tuser_o)))
    else $error("output word changed while stalled");

  // no output word appears without an input word
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o && !(s_axis_tvalid_i && s_axis_tready_o)) |=> !m_axis_tvalid_o)
    else $error("output word without input");

  // ready stays low until the output drains
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tready_o && !(m_axis_tvalid_o && m_axis_tready_i)) |=> !s_axis_tready_o)
    else $error("input ready rose without output drain");

  // patched PID bytes carry all-ones PID bits and no sync error
  a_patch_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (m_axis_tdata_o[4:0] == 5'h1F) && !m_axis_tuser_o[1])
    else $error("patched word has wrong PID bits");

endmodule

bind ts_pid_null_patcher_core tspnp_checker u_tspnp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/sv/testbench.sv =====
// Self-checking bench for ts_pid_null_patcher_core: directed table, then random datagrams.
module testbench;
  import tspnp_pkg::*;

  localparam int unsigned NumPhases      = 8;
  localparam int unsigned PhaseWords     = 28;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned DirRows        = 23;
  localparam int unsigned CfgFirstUnused = int'(CfgPidWordD) + 1;

  typedef struct packed {
    logic [7:0]      in_byte;
    logic            first;
    logic [LenW-1:0] len;
    logic            last;
  } in_word_t;

  typedef struct packed {
    logic [7:0]      in_byte;
    logic            first;
    logic [LenW-1:0] len;
    logic            last;
    logic            typed;
    logic [7:0]      e_byte;
    logic            e_end;
    logic            e_repl;
    logic            e_serr;
  } dir_row_t;

  // PID table for this part: entry0 0x0000, entry1 0x1FFF, entries 2 and 3 both 0x0ABC
  localparam dir_row_t DirTbl [DirRows] = '{
    '{8'h47, 1'b0, 11'd0,    1'b0, 1'b1, 8'h47, 1'b0, 1'b0, 1'b0},  // no first mark yet
    '{8'h1F, 1'b0, 11'd0,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 11'd0,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},  // PID 8191 listed
    '{8'h00, 1'b1, 11'd188,  1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1},  // bad sync
    '{8'h40, 1'b0, 11'd0,    1'b0, 1'b1, 8'h40, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 11'd0,    1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b1, 11'd190,  1'b0, 1'b1, 8'h80, 1'b0, 1'b0, 1'b0},  // 2-byte header
    '{8'h47, 1'b0, 11'd0,    1'b0, 1'b1, 8'h47, 1'b0, 1'b0, 1'b0},
    '{8'h47, 1'b0, 11'd0,    1'b0, 1'b1, 8'h47, 1'b0, 1'b0, 1'b0},
    '{8'hEA, 1'b0, 11'd0,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'hBC, 1'b0, 11'd0,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},  // duplicate entries
    '{8'h47, 1'b1, 11'd188,  1'b0, 1'b1, 8'h47, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 11'd0,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h47, 1'b1, 11'd0,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},  // new datagram flushes held byte
    '{8'hA0, 1'b0, 11'd0,    1'b1, 1'b1, 8'hA0, 1'b1, 1'b0, 1'b0},  // ends at byte1
    '{8'h00, 1'b0, 11'd0,    1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h47, 1'b1, 11'd188,  1'b0, 1'b1, 8'h47, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 11'd0,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 11'd0,    1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},  // PID 0 listed
    '{8'h47, 1'b1, 11'd188,  1'b0, 1'b1, 8'h47, 1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b0, 11'd0,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 11'd0,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0},  // PID 0x100 not listed
    '{8'hFF, 1'b1, 11'd2047, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [23:0]         s_axis_tdata_i;
  logic                s_axis_tlast_i;
  logic [0:0]          s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [7:0]          m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic [2:0]          m_axis_tuser_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [IdxW-1:0]     cfg_index_i;
  logic [WordW-1:0]    cfg_data_i;

  // predictor copy of the register file and packet state
  logic [CntW-1:0]     pid_cnt = '0;
  logic [WordW-1:0]    pid_word [NumWords] = '{default: '0};
  int unsigned         hdr_left = 0;
  int unsigned         pkt_pos = 0;
  logic [7:0]          held_byte = '0;
  logic                sync_ok = 1'b0;
  logic                in_hdr = 1'b0;

  res_t                step_q [$];
  res_t                out_q [$];
  int unsigned         src_idle_pct = 0;
  int unsigned         snk_stall_pct = 0;
  int unsigned         sent_cnt = 0;
  int unsigned         res_cnt = 0;
  int unsigned         err_cnt = 0;
  int unsigned         cycles = 0;

  ts_pid_null_patcher_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL ts_pid_null_patcher_core");
      $finish;
    end
  end

  function automatic void push_out(logic [7:0] b, logic e, logic r, logic s);
    res_t x;
    x.out_byte        = b;
    x.end_of_datagram = e;
    x.pid_replaced    = r;
    x.sync_error      = s;
    x.last_of_step    = 1'b0;
    step_q.push_back(x);
  endfunction

  function automatic logic pid_on_list(logic [PidW-1:0] pid);
    int unsigned n;
    n = (pid_cnt > MaxPids) ? MaxPids : pid_cnt;
    for (int unsigned i = 0; i < n; i++) begin
      if (pid_word[i / PidsPerWord][(i % PidsPerWord) * PidW +: PidW] == pid) return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected output words for one accepted input word, left in step_q
  task automatic predict_patch(input in_word_t w);
    logic            pending;
    logic [PidW-1:0] pid;
    step_q.delete();
    pending = (pkt_pos == 2) && sync_ok && !in_hdr;
    if (w.first) begin
      if (pending) begin
        push_out(held_byte, 1'b0, 1'b0, 1'b0);
        sync_ok = 1'b0;
      end
      hdr_left = w.len % PacketBytes;
      pkt_pos  = 0;
      in_hdr   = (hdr_left != 0);
      pending  = 1'b0;
    end
    if (in_hdr) begin
      push_out(w.in_byte, w.last, 1'b0, 1'b0);
      if (hdr_left > 0) hdr_left--;
      if (hdr_left == 0) in_hdr = 1'b0;
    end else if (pkt_pos == 0) begin
      sync_ok = (w.in_byte == SyncByte);
      push_out(w.in_byte, w.last, 1'b0, !sync_ok);
      pkt_pos = (pkt_pos + 1) % PacketBytes;
    end else if (pkt_pos == 1) begin
      if (sync_ok && !w.last) begin
        held_byte = w.in_byte;
      end else begin
        sync_ok = 1'b0;
        push_out(w.in_byte, w.last, 1'b0, 1'b0);
      end
      pkt_pos = (pkt_pos + 1) % PacketBytes;
    end else if (pending) begin
      pid = {held_byte[4:0], w.in_byte};
      if (pid_on_list(pid)) begin
        push_out(held_byte | {3'b000, PidHiMask}, 1'b0, 1'b1, 1'b0);
        push_out(NullLow, w.last, 1'b1, 1'b0);
      end else begin
        push_out(held_byte, 1'b0, 1'b0, 1'b0);
        push_out(w.in_byte, w.last, 1'b0, 1'b0);
      end
      pkt_pos = (pkt_pos + 1) % PacketBytes;
    end else begin
      push_out(w.in_byte, w.last, 1'b0, 1'b0);
      pkt_pos = (pkt_pos + 1) % PacketBytes;
    end
    if (step_q.size() != 0) step_q[step_q.size() - 1].last_of_step = 1'b1;
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input res_t want);
    if (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < src_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b00000, w.len, w.in_byte};
    s_axis_tlast_i  <= w.last;
    s_axis_tuser_i  <= w.first;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_patch(w);
    if (typed) out_q.push_back(want);
    else foreach (step_q[k]) out_q.push_back(step_q[k]);
    sent_cnt++;
  endtask

  // leaves cfg_valid_i high so back-to-back writes never toggle it within one step
  task automatic cfg_write(input logic [IdxW-1:0] idx, input logic [WordW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgPidCount) pid_cnt = data[CntW-1:0];
    else if (idx >= CfgPidWordA && idx <= CfgPidWordD) pid_word[2'(idx - CfgPidWordA)] = data;
  endtask

  task automatic wait_results_done(input int unsigned settle);
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (out_q.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic load_pid_table(input int unsigned cnt);
    logic [WordW-1:0] cw;
    logic [WordW-1:0] pw;
    logic [PidW-1:0]  ent;
    ent = PidW'($urandom);
    cw = WordW'({$urandom, $urandom});
    cw[CntW-1:0] = CntW'(cnt);
    cfg_write(CfgPidCount, cw);
    for (int k = 0; k < NumWords; k++) begin
      pw = '0;
      for (int e = 0; e < PidsPerWord; e++) begin
        case ($urandom_range(3, 0))
          0: ent = '0;
          1: ent = '1;
          2: ent = ent;
          default: ent = PidW'($urandom);
        endcase
        pw[e * PidW +: PidW] = ent;
      end
      cfg_write(cfg_reg_e'(int'(CfgPidWordA) + k), pw);
    end
    cfg_write(IdxW'($urandom_range((1 << IdxW) - 1, CfgFirstUnused)),
              WordW'({$urandom, $urandom}));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_datagram();
    int unsigned     roll;
    int unsigned     hdr;
    int unsigned     n;
    int unsigned     len;
    logic [PidW-1:0] pid;
    logic            full;
    logic            bad_sync;
    logic            end_mark;
    in_word_t        w;
    roll = $urandom_range(99, 0);
    if (roll < 65) begin
      // well-formed start of a datagram, usually cut short after the PID bytes
      hdr  = ($urandom_range(9, 0) == 0) ? $urandom_range(PacketBytes - 1, 0)
                                         : $urandom_range(12, 0);
      full = ($urandom_range(24, 0) == 0);
      len  = hdr + PacketBytes * (full ? 1 : $urandom_range(2, 1));
      n    = hdr + (full ? PacketBytes : $urandom_range(8, 2));
      if ($urandom_range(1, 0) == 0) begin
        roll = $urandom_range(MaxPids - 1, 0);
        pid  = pid_word[roll / PidsPerWord][(roll % PidsPerWord) * PidW +: PidW];
      end else begin
        pid = PidW'($urandom);
      end
      bad_sync = ($urandom_range(9, 0) == 0);
      for (int unsigned i = 0; i < n; i++) begin
        w.first = (i == 0);
        w.len   = (i == 0) ? LenW'(len) : LenW'($urandom);
        w.last  = (i == n - 1);
        if (i < hdr) w.in_byte = 8'($urandom);
        else if (i == hdr) w.in_byte = bad_sync ? 8'($urandom) : SyncByte;
        else if (i == hdr + 1) w.in_byte = {3'($urandom), pid[PidW-1:8]};
        else if (i == hdr + 2) w.in_byte = pid[7:0];
        else w.in_byte = 8'($urandom);
        send_word(w, 1'b0, '0);
      end
    end else if (roll < 85) begin
      // broken datagram: odd length, random content, maybe no end mark
      n        = $urandom_range(6, 1);
      len      = ($urandom_range(1, 0) == 0) ? PacketBytes * $urandom_range(10, 0)
                                             : $urandom_range((1 << LenW) - 1, 0);
      end_mark = 1'($urandom_range(1, 0));
      for (int unsigned i = 0; i < n; i++) begin
        w.first   = (i == 0);
        w.len     = (i == 0) ? LenW'(len) : LenW'($urandom);
        w.last    = end_mark && (i == n - 1);
        w.in_byte = (i == 0 && $urandom_range(1, 0) == 0) ? SyncByte : 8'($urandom);
        send_word(w, 1'b0, '0);
      end
    end else begin
      n = $urandom_range(4, 1);
      for (int unsigned i = 0; i < n; i++) begin
        w.first   = 1'b0;
        w.len     = LenW'($urandom);
        w.last    = ($urandom_range(3, 0) == 0);
        w.in_byte = 8'($urandom);
        send_word(w, 1'b0, '0);
      end
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : out_check
    res_t want;
    res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tuser_o[2], m_axis_tuser_o[1], m_axis_tuser_o[0], m_axis_tlast_o,
             m_axis_tdata_o};
      res_cnt++;
      if (out_q.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, got);
        err_cnt++;
      end else begin
        want = out_q.pop_front();
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("end_of_datagram", 8'(want.end_of_datagram), 8'(got.end_of_datagram));
        check_field("pid_replaced", 8'(want.pid_replaced), 8'(got.pid_replaced));
        check_field("sync_error", 8'(want.sync_error), 8'(got.sync_error));
        check_field("last_of_step", 8'(want.last_of_step), 8'(got.last_of_step));
      end
    end
    m_axis_tready_i <= ($urandom_range(99, 0) >= snk_stall_pct);
  end

  initial begin : stim
    in_word_t    w;
    res_t        want;
    int unsigned cnt;
    int unsigned phase_end;
    bit          held_off;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    s_axis_tuser_i  <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CfgPidCount;
    cfg_data_i      <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_write(CfgPidCount, WordW'(4));
    cfg_write(CfgPidWordA, {13'h0ABC, 13'h0ABC, 13'h1FFF, 13'h0000});
    cfg_write(CfgPidWordB, WordW'({$urandom, $urandom}));
    cfg_write(CfgPidWordC, WordW'({$urandom, $urandom}));
    cfg_write(CfgPidWordD, WordW'({$urandom, $urandom}));
    cfg_valid_i <= 1'b0;
    for (int i = 0; i < DirRows; i++) begin
      w    = {DirTbl[i].in_byte, DirTbl[i].first, DirTbl[i].len, DirTbl[i].last};
      want = {1'b1, DirTbl[i].e_serr, DirTbl[i].e_repl, DirTbl[i].e_end, DirTbl[i].e_byte};
      send_word(w, DirTbl[i].typed, want);
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_results_done(SettleCycles);
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 64; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 64; end
        default: begin src_idle_pct = 27; snk_stall_pct = 27; end
      endcase
      case (p)
        0: cnt = 0;
        1: cnt = MaxPids;
        2: cnt = (1 << CntW) - 1;
        3: cnt = $urandom_range((1 << CntW) - 2, MaxPids + 1);
        4, 6: cnt = $urandom_range(MaxPids - 1, 1);
        5: cnt = MaxPids;
        default: cnt = $urandom_range((1 << CntW) - 1, 0);
      endcase
      load_pid_table(cnt);
      phase_end = sent_cnt + PhaseWords;
      held_off  = 1'b0;
      while (sent_cnt < phase_end) begin
        if (!held_off && sent_cnt + PhaseWords / 2 >= phase_end) begin
          wait_results_done(0);
          held_off = 1'b1;
        end
        send_datagram();
      end
    end

    wait_results_done(SettleCycles * 2);
    if (out_q.size() != 0) begin
      $display("%0t %0d expected words never arrived", $time, out_q.size());
      err_cnt++;
    end
    $display("Sent %0d input words over %0d PID table settings and four idling mixes,",
             sent_cnt, NumPhases + 1);
    $display("compared %0d result words, %0d mismatches.", res_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS ts_pid_null_patcher_core");
    end else begin
      $display("FAIL ts_pid_null_patcher_core");
    end
    $finish;
  end

endmodule

// ===== ts_pid_null_patcher_core.f =====
rtl/core/tspnp_pkg.sv
rtl/core/ts_pid_null_patcher_core.sv
rtl/core/tspnp_checker.sv
tb/sv/testbench.sv
